// ===== rtl/rrts_pkg.sv =====
// Package of types and constants for the round-robin thread scheduler.
package rrts_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);

  // Operation codes carried by func.
  localparam logic [2:0] FN_TICK    = 3'd0;
  localparam logic [2:0] FN_YIELD   = 3'd1;
  localparam logic [2:0] FN_CREATE  = 3'd2;
  localparam logic [2:0] FN_EXIT    = 3'd3;
  localparam logic [2:0] FN_SUSPEND = 3'd4;
  localparam logic [2:0] FN_RESUME  = 3'd5;
  localparam logic [2:0] FN_DELAY   = 3'd6;

  // Slot state codes.
  localparam logic [2:0] ST_UNUSED    = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_RUNNING   = 3'd2;
  localparam logic [2:0] ST_BLOCKED   = 3'd3;
  localparam logic [2:0] ST_SUSPENDED = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  target_slot;
    logic [15:0] slice_length;
    logic [15:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic        switched;
    logic [3:0]  current_slot;
    logic [4:0]  waiting_count;
    logic [3:0]  created_slot;
    logic        table_full;
  } out_item_t;

endpackage

// ===== rtl/round_robin_thread_scheduler_core.sv =====
// Top level of the round-robin thread scheduler with its slot sweep sequencer.
//
//  channel | direction | payload
//  in      | input     | in_item_t  (in_valid / in_ready)
//  out     | output    | out_item_t (out_valid / out_ready)
//
// Tick sweeps the delay counters one slot per cycle, then the slice step
// runs. A yield search walks one slot per cycle; create searches the same
// way, and exit, suspend and an expired slice also search. Reset is
// synchronous and needs no clearing pass. A result waits in the output
// register until transferred; the next item may be taken meanwhile, and
// it then waits in its final step until the output register is free.
module round_robin_thread_scheduler_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrts_pkg::in_item_t  in,
  output logic                out_valid,
  input  logic                out_ready,
  output rrts_pkg::out_item_t out
);
  import rrts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_TICK   = 6'b000010,
    S_SLICE  = 6'b000100,
    S_SEARCH = 6'b001000,
    S_CREATE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  in_item_t item;

  logic [2:0]  slot_state [SLOTS];
  logic [15:0] delay_count [SLOTS];
  logic [15:0] slice_reload [SLOTS];
  logic [15:0] slice_left [SLOTS];
  logic [IDX_W-1:0] running_index;

  logic [IDX_W-1:0] idx;
  logic [4:0]       cnt;
  logic             switched;
  logic [4:0]       waiting;
  logic [IDX_W-1:0] created;
  logic             full;

  logic [IDX_W-1:0] idx_inc;
  logic [15:0]      slice_dec;
  logic             tgt_ok;

  assign idx_inc = (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
  assign slice_dec = slice_left[running_index] - 16'd1;
  assign tgt_ok = 32'(item.target_slot) < SLOTS;
  assign in_ready = (state == S_IDLE);

  // Sequencer: one slot visited per cycle by the shared walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      running_index <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] <= (i == 0) ? ST_RUNNING : ST_UNUSED;
        delay_count[i] <= '0;
        slice_reload[i] <= (i == 0) ? 16'd1 : 16'd0;
        slice_left[i] <= (i == 0) ? 16'd1 : 16'd0;
      end
    end else begin
      // Output register: loaded as an item finishes, cleared by its transfer.
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in;
            switched <= 1'b0;
            waiting <= '0;
            created <= '0;
            full <= 1'b0;
            cnt <= '0;
            unique case (in.func)
              FN_TICK: begin
                idx <= '0;
                state <= S_TICK;
              end
              FN_YIELD: begin
                idx <= running_index;
                state <= S_SEARCH;
              end
              FN_CREATE: begin
                idx <= '0;
                state <= S_CREATE;
              end
              FN_EXIT: begin
                idx <= running_index;
                if (running_index != '0) begin
                  slot_state[running_index] <= ST_UNUSED;
                  state <= S_SEARCH;
                end else begin
                  state <= S_DONE;
                end
              end
              FN_SUSPEND: begin
                idx <= running_index;
                if (32'(in.target_slot) < SLOTS) begin
                  slot_state[in.target_slot[IDX_W-1:0]] <= ST_SUSPENDED;
                  state <= S_SEARCH;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                idx <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_TICK: begin
          // Release or count down one slot's delay.
          if (delay_count[idx] == '0) begin
            if (slot_state[idx] == ST_BLOCKED) slot_state[idx] <= ST_READY;
          end else begin
            delay_count[idx] <= delay_count[idx] - 16'd1;
          end
          idx <= idx_inc;
          if (idx == IDX_W'(SLOTS - 1)) state <= S_SLICE;
        end
        S_SLICE: begin
          // Slice countdown of the current slot.
          if (slice_dec == '0) begin
            slice_left[running_index] <= slice_reload[running_index];
            idx <= running_index;
            state <= S_SEARCH;
          end else begin
            slice_left[running_index] <= slice_dec;
            state <= S_DONE;
          end
        end
        S_SEARCH: begin
          // Round-robin walk for the next ready slot.
          if (slot_state[idx] == ST_READY) begin
            if (slot_state[running_index] == ST_RUNNING && idx != running_index)
              slot_state[running_index] <= ST_READY;
            slot_state[idx] <= ST_RUNNING;
            switched <= (idx != running_index);
            running_index <= idx;
            state <= S_DONE;
          end else begin
            if ((slot_state[idx] == ST_BLOCKED || slot_state[idx] == ST_SUSPENDED)
                && cnt != 5'd31)
              cnt <= cnt + 5'd1;
            idx <= idx_inc;
            if (idx_inc == running_index) begin
              waiting <= ((slot_state[idx] == ST_BLOCKED ||
                           slot_state[idx] == ST_SUSPENDED) && cnt != 5'd31)
                         ? cnt + 5'd1 : cnt;
              state <= S_DONE;
            end
          end
        end
        S_CREATE: begin
          // First unused slot takes the new thread.
          if (slot_state[idx] == ST_UNUSED) begin
            delay_count[idx] <= '0;
            slice_reload[idx] <= item.slice_length;
            slice_left[idx] <= item.slice_length;
            slot_state[idx] <= ST_READY;
            created <= idx;
            state <= S_DONE;
          end else begin
            idx <= idx_inc;
            if (idx == IDX_W'(SLOTS - 1)) begin
              full <= 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // Every operation finishes here once the output register is free; resume and delay update their slot here.
          if (!out_valid || out_ready) begin
            if (item.func == FN_RESUME && tgt_ok &&
                slot_state[item.target_slot[IDX_W-1:0]] == ST_SUSPENDED)
              slot_state[item.target_slot[IDX_W-1:0]] <= ST_READY;
            if (item.func == FN_DELAY && tgt_ok) begin
              delay_count[item.target_slot[IDX_W-1:0]] <= item.delay_ticks;
              slot_state[item.target_slot[IDX_W-1:0]] <= ST_BLOCKED;
            end
            out.switched <= switched;
            out.current_slot <= 4'(running_index);
            out.waiting_count <= waiting;
            out.created_slot <= 4'(created);
            out.table_full <= full;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/rrts_checker.sv =====
// Checker that watches both channels, predicts each result and compares it.
module rrts_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rrts_pkg::in_item_t  in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rrts_pkg::out_item_t out,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  logic [2:0]  sched_state [SLOTS];
  logic [15:0] sched_delay [SLOTS];
  logic [15:0] sched_reload [SLOTS];
  logic [15:0] sched_left [SLOTS];
  logic [3:0]  sched_cur;
  out_item_t   expected_results [$];

  assign pending = expected_results.size();

  // Round-robin search from the current slot for the first ready slot.
  function automatic void search_ready(inout out_item_t r);
    logic [3:0] idx;
    logic [4:0] cnt;
    idx = sched_cur;
    cnt = '0;
    while (sched_state[idx] != ST_READY) begin
      if (sched_state[idx] == ST_BLOCKED || sched_state[idx] == ST_SUSPENDED) begin
        if (cnt < 5'd31) cnt = cnt + 5'd1;
      end
      idx = idx + 4'd1;
      if (idx == sched_cur) begin
        r.waiting_count = cnt;
        return;
      end
    end
    if (sched_state[sched_cur] == ST_RUNNING) sched_state[sched_cur] = ST_READY;
    sched_state[idx] = ST_RUNNING;
    r.switched = (idx != sched_cur);
    sched_cur = idx;
  endfunction

  // Applies one operation to the predicted table and returns its result.
  function automatic out_item_t schedule_item(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.func)
      FN_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (sched_delay[i] == 16'd0) begin
            if (sched_state[i] == ST_BLOCKED) sched_state[i] = ST_READY;
          end else sched_delay[i] = sched_delay[i] - 16'd1;
        end
        sched_left[sched_cur] = sched_left[sched_cur] - 16'd1;
        if (sched_left[sched_cur] == 16'd0) begin
          sched_left[sched_cur] = sched_reload[sched_cur];
          search_ready(r);
        end
      end
      FN_YIELD: search_ready(r);
      FN_CREATE: begin
        r.table_full = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (r.table_full && sched_state[i] == ST_UNUSED) begin
            sched_delay[i] = '0;
            sched_reload[i] = it.slice_length;
            sched_left[i] = it.slice_length;
            sched_state[i] = ST_READY;
            r.created_slot = 4'(i);
            r.table_full = 1'b0;
          end
        end
      end
      FN_EXIT: begin
        if (sched_cur != 4'd0) begin
          sched_state[sched_cur] = ST_UNUSED;
          search_ready(r);
        end
      end
      FN_SUSPEND: begin
        sched_state[it.target_slot] = ST_SUSPENDED;
        search_ready(r);
      end
      FN_RESUME: begin
        if (sched_state[it.target_slot] == ST_SUSPENDED)
          sched_state[it.target_slot] = ST_READY;
      end
      FN_DELAY: begin
        sched_delay[it.target_slot] = it.delay_ticks;
        sched_state[it.target_slot] = ST_BLOCKED;
      end
      default: ;
    endcase
    r.current_slot = sched_cur;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // Prediction on each input transfer, comparison on each output transfer.
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        sched_state[i] = ST_UNUSED;
        sched_delay[i] = '0;
        sched_reload[i] = '0;
        sched_left[i] = '0;
      end
      sched_state[0] = ST_RUNNING;
      sched_reload[0] = 16'd1;
      sched_left[0] = 16'd1;
      sched_cur = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfers waiting", 1, 0);
        end else begin
          e = expected_results.pop_front();
          if (out.switched !== e.switched)
            report_mismatch("switched", int'(out.switched), int'(e.switched));
          if (out.current_slot !== e.current_slot)
            report_mismatch("current_slot", int'(out.current_slot),
                            int'(e.current_slot));
          if (out.waiting_count !== e.waiting_count)
            report_mismatch("waiting_count", int'(out.waiting_count),
                            int'(e.waiting_count));
          if (out.created_slot !== e.created_slot)
            report_mismatch("created_slot", int'(out.created_slot),
                            int'(e.created_slot));
          if (out.table_full !== e.table_full)
            report_mismatch("table_full", int'(out.table_full), int'(e.table_full));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(schedule_item(in));
    end
  end
endmodule

// ===== tb/tb.sv =====
// Top of the scheduler testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out;
  int        fail_count;
  int        pending;
  bit        quiet_phase = 1'b0;
  bit        hold_off = 1'b0;
  int        idle_cycles = 0;

  round_robin_thread_scheduler_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in(in),
    .out_valid(out_valid), .out_ready(out_ready), .out(out)
  );

  rrts_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in(in),
    .out_valid(out_valid), .out_ready(out_ready), .out(out),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, with a long hold-off on request.
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= quiet_phase || ($urandom_range(99) >= 24);
  end

  // Offers one item; valid stays up after the transfer until the next item or an idle gap.
  task automatic send_item(logic [2:0] f, logic [3:0] t, logic [15:0] s, logic [15:0] d);
    if (!quiet_phase) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in <= '{func: f, target_slot: t, slice_length: s, delay_ticks: d};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Picks an operation: mostly well-formed scheduling traffic.
  task automatic send_random();
    int r;
    logic [15:0] s;
    logic [15:0] d;
    r = $urandom_range(99);
    s = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
    d = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
    if (r < 35) send_item(FN_TICK, 4'($urandom), s, d);
    else if (r < 47) send_item(FN_YIELD, 4'($urandom), s, d);
    else if (r < 60) send_item(FN_CREATE, 4'($urandom), s, d);
    else if (r < 68) send_item(FN_EXIT, 4'($urandom), s, d);
    else if (r < 76) send_item(FN_SUSPEND, 4'($urandom), s, d);
    else if (r < 88) send_item(FN_RESUME, 4'($urandom), s, d);
    else if (r < 97) send_item(FN_DELAY, 4'($urandom), s, d);
    else send_item(3'd7, 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: extremes and special cases.
    send_item(FN_TICK, 4'd0, 16'd0, 16'd0);          // slice reload with no ready slot
    send_item(FN_EXIT, 4'd0, 16'd0, 16'd0);          // exit of slot zero is ignored
    send_item(FN_CREATE, 4'd0, 16'hFFFF, 16'hFFFF);
    send_item(FN_CREATE, 4'd15, 16'd0, 16'd0);       // zero slice acts as the longest
    send_item(FN_CREATE, 4'd0, 16'd1, 16'd0);
    send_item(FN_YIELD, 4'd0, 16'd0, 16'd0);
    send_item(FN_DELAY, 4'd0, 16'd0, 16'hFFFF);
    send_item(FN_DELAY, 4'd3, 16'd0, 16'd0);
    send_item(FN_SUSPEND, 4'd1, 16'd0, 16'd0);       // suspend the running slot
    send_item(FN_RESUME, 4'd1, 16'd0, 16'd0);
    send_item(FN_RESUME, 4'd15, 16'd0, 16'd0);       // resume of an unused slot
    send_item(FN_TICK, 4'd0, 16'd0, 16'd0);
    send_item(FN_YIELD, 4'd0, 16'd0, 16'd0);
    send_item(FN_EXIT, 4'd0, 16'd0, 16'd0);
    send_item(3'd7, 4'd15, 16'hFFFF, 16'hFFFF);      // unknown operation
    for (int i = 0; i < 16; i++) send_item(FN_CREATE, 4'd0, 16'd2, 16'd0);  // fills table
    for (int i = 0; i < 16; i++) send_item(FN_SUSPEND, 4'(i), 16'd0, 16'd0);  // failed search
    send_item(FN_YIELD, 4'd0, 16'd0, 16'd0);

    // Stretch with no idling, with a long receiver hold-off.
    quiet_phase = 1'b1;
    fork
      begin
        @(negedge clk);
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 150; i++) send_random();
    join
    quiet_phase = 1'b0;

    // Random part.
    for (int i = 0; i < 1250; i++) send_random();
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/rrts_pkg.sv
rtl/round_robin_thread_scheduler_core.sv
tb/rrts_checker.sv
tb/tb.sv
